// File: sv/etu_pkg.sv
// types, constants, decode function and microcode table of the escape text unescaper
package etu_pkg;

   localparam int PEND_DEPTH = 5;
   localparam int WIN_DEPTH  = PEND_DEPTH + 1;
   localparam int MAX_RES    = 6;

   localparam logic [7:0] CH_BS     = 8'h5C;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LC_E   = 8'h65;
   localparam logic [7:0] CH_UC_E   = 8'h45;
   localparam logic [7:0] CH_LC_S   = 8'h73;
   localparam logic [7:0] CH_LC_C   = 8'h63;
   localparam logic [7:0] CH_LC_X   = 8'h78;
   localparam logic [7:0] CH_UC_X   = 8'h58;
   localparam logic [7:0] CH_LC_U   = 8'h75;
   localparam logic [7:0] CH_UC_U   = 8'h55;
   localparam logic [7:0] CASE_BIT  = 8'h20;

   typedef logic [WIN_DEPTH-1:0][7:0] win_type;
   typedef logic [2:0] len_type;
   typedef logic [2:0] res_idx_type;

   typedef struct packed {
      logic [2:0]      used;
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
   } dec_type;

   typedef enum logic [1:0] {
      OP_ACCEPT,
      OP_DECODE,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_ACCEPT,
      COND_MORE,
      COND_DONE
   } cond_type;

   typedef logic [1:0] step_type;

   localparam step_type STEP_ACCEPT = 2'd0;
   localparam step_type STEP_DECODE = 2'd1;
   localparam step_type STEP_EMIT   = 2'd2;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      case (s)
         STEP_ACCEPT: w = '{OP_ACCEPT, COND_ACCEPT, STEP_DECODE, STEP_ACCEPT};
         STEP_DECODE: w = '{OP_DECODE, COND_MORE, STEP_DECODE, STEP_EMIT};
         STEP_EMIT:   w = '{OP_EMIT, COND_DONE, STEP_ACCEPT, STEP_EMIT};
         default:     w = '{OP_ACCEPT, COND_ACCEPT, STEP_DECODE, STEP_ACCEPT};
      endcase
      return w;
   endfunction

   function automatic logic hex_ok(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      return (c inside {[8'h30:8'h39]}) ? c[3:0] : 4'(c[3:0] + 4'd9);
   endfunction

   function automatic logic oct_ok(input logic [7:0] c);
      return c inside {[8'h30:8'h37]};
   endfunction

   function automatic dec_type give_one(input logic [7:0] v, input logic [2:0] used);
      dec_type r;
      r.used  = used;
      r.cnt   = 2'd1;
      r.bytes = {16'h0000, v};
      return r;
   endfunction

   // decide the form at the front of the window; used of zero means wait
   function automatic dec_type decide(input win_type b, input len_type len, input logic fin);
      dec_type         r;
      dec_type         lit;
      dec_type         hold;
      logic [7:0]      c;
      logic [7:0]      d;
      logic            short;
      logic            bad;
      logic            stop;
      logic            waiting;
      logic [8:0]      oval;
      logic [2:0]      j;
      logic [15:0]     cp;
      c     = b[0];
      d     = b[1];
      lit   = give_one(c, 3'd1);
      hold  = '0;
      short = 1'b0;
      bad   = 1'b0;
      stop  = 1'b0;
      waiting = 1'b0;
      oval  = '0;
      j     = 3'd2;
      cp    = '0;
      r     = lit;
      if (c == CH_BS) begin
         if (len < 3'd2) begin
            r = fin ? lit : hold;
         end else if (d == CH_BS) begin
            r = give_one(CH_BS, 3'd2);
         end else if (d inside {CH_LC_E, CH_UC_E}) begin
            r = give_one(CH_ESC, 3'd2);
         end else if (d inside {CH_LC_X, CH_UC_X}) begin
            for (int k = 2; k < 4; k++) begin
               if (!short && !bad) begin
                  if (3'(k) >= len) short = 1'b1;
                  else if (!hex_ok(b[k])) bad = 1'b1;
               end
            end
            if (short) r = fin ? lit : hold;
            else if (bad) r = lit;
            else r = give_one({hex_val(b[2]), hex_val(b[3])}, 3'd4);
         end else if (d inside {CH_LC_U, CH_UC_U}) begin
            for (int k = 2; k < 6; k++) begin
               if (!short && !bad) begin
                  if (3'(k) >= len) short = 1'b1;
                  else if (!hex_ok(b[k])) bad = 1'b1;
               end
            end
            cp = {hex_val(b[2]), hex_val(b[3]), hex_val(b[4]), hex_val(b[5])};
            if (short) begin
               r = fin ? lit : hold;
            end else if (bad) begin
               r = lit;
            end else if (cp <= 16'h007F) begin
               r = give_one(cp[7:0], 3'd6);
            end else if (cp <= 16'h07FF) begin
               r.used  = 3'd6;
               r.cnt   = 2'd2;
               r.bytes = {8'h00, 8'h80 | {2'b00, cp[5:0]}, 8'hC0 | {3'b000, cp[10:6]}};
            end else begin
               r.used  = 3'd6;
               r.cnt   = 2'd3;
               r.bytes = {8'h80 | {2'b00, cp[5:0]}, 8'h80 | {2'b00, cp[11:6]},
                          8'hE0 | {4'h0, cp[15:12]}};
            end
         end else if (oct_ok(d)) begin
            oval = {6'd0, d[2:0]};
            for (int k = 2; k < 4; k++) begin
               if (!stop) begin
                  if (3'(k) >= len) begin
                     waiting = !fin;
                     stop    = 1'b1;
                  end else if (!oct_ok(b[k])) begin
                     stop = 1'b1;
                  end else begin
                     oval = {oval[5:0], b[k][2:0]};
                     j    = 3'(k + 1);
                  end
               end
            end
            r = waiting ? hold : give_one(oval[7:0], j);
         end else begin
            r = lit;
         end
      end else if (c == CH_CARET) begin
         if (len < 3'd2) r = fin ? lit : hold;
         else if (d == CH_LBRACK) r = give_one(CH_ESC, 3'd2);
         else r = lit;
      end else if (c inside {CH_LC_E, CH_UC_E}) begin
         for (int k = 1; k < 4; k++) begin
            if (!short && !bad) begin
               if (3'(k) >= len) short = 1'b1;
               else if (k == 1) bad = (b[1] | CASE_BIT) != CH_LC_S;
               else if (k == 2) bad = (b[2] | CASE_BIT) != CH_LC_C;
               else bad = !(b[3] inside {CH_LBRACK, CH_RBRACK});
            end
         end
         if (short) r = fin ? lit : hold;
         else if (bad) r = lit;
         else r = give_one(CH_ESC, 3'd3);
      end
      return r;
   endfunction

endpackage

// File: sv/escape_text_unescaper.sv
// escape text unescaper top level: microcoded step sequencer over a lookahead window
// steps: accept, then one decode step per decided form, plus one when bytes stay waiting or
//   nothing is decided, then emit, giving out the result bytes in order, held by output stall;
//   the input stalls outside accept, so a new request waits until the results are given out
// reset: synchronous, clears the step counter, pending count, result count and output index;
//   window and result bytes hold anything until written; the input stalls during reset
module escape_text_unescaper
   import etu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_text_last
);

   step_type                  pc_ff, pc_in;
   win_type                   win_ff, win_in;
   len_type                   len_ff, len_in;
   logic                      fin_ff, fin_in;
   logic [MAX_RES-1:0][7:0]   res_ff, res_in;
   res_idx_type               res_cnt_ff, res_cnt_in;
   res_idx_type               out_idx_ff, out_idx_in;

   ucode_type                 uw;
   dec_type                   dec;
   logic                      cond;
   logic                      req_acc;
   logic                      rsp_acc;
   logic                      is_last;
   logic [3:0]                src;
   res_idx_type               off;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= STEP_ACCEPT;
         len_ff     <= '0;
         res_cnt_ff <= '0;
         out_idx_ff <= '0;
      end else begin
         pc_ff      <= pc_in;
         len_ff     <= len_in;
         res_cnt_ff <= res_cnt_in;
         out_idx_ff <= out_idx_in;
      end
      win_ff <= win_in;
      fin_ff <= fin_in;
      res_ff <= res_in;
   end

   assign uw  = ucode_rom(pc_ff);
   assign dec = decide(win_ff, len_ff, fin_ff);

   assign req_stall     = reset || (uw.op != OP_ACCEPT);
   assign rsp_valid     = (uw.op == OP_EMIT) && (res_cnt_ff != '0);
   assign rsp_out_byte  = res_ff[out_idx_ff];
   assign is_last       = (out_idx_ff == 3'(res_cnt_ff - 3'd1));
   assign rsp_run_last  = is_last;
   assign rsp_text_last = is_last && fin_ff;
   assign req_acc       = req_valid && !req_stall;
   assign rsp_acc       = rsp_valid && !rsp_stall;

   always_comb begin
      win_in     = win_ff;
      len_in     = len_ff;
      fin_in     = fin_ff;
      res_in     = res_ff;
      res_cnt_in = res_cnt_ff;
      out_idx_in = out_idx_ff;
      src        = '0;
      off        = '0;
      case (uw.cond)
         COND_ACCEPT: cond = req_acc;
         COND_MORE:   cond = (dec.used != '0) && (dec.used != len_ff);
         COND_DONE:   cond = (res_cnt_ff == '0) || (rsp_acc && is_last);
         default:     cond = 1'b0;
      endcase
      case (uw.op)
         OP_ACCEPT: begin
            if (req_acc) begin
               for (int i = 0; i < WIN_DEPTH; i++) begin
                  if (3'(i) == len_ff) win_in[i] = req_in_byte;
               end
               len_in     = 3'(len_ff + 3'd1);
               fin_in     = req_end_of_text;
               res_cnt_in = '0;
               out_idx_in = '0;
            end
         end
         OP_DECODE: begin
            if (dec.used != '0) begin
               for (int i = 0; i < WIN_DEPTH; i++) begin
                  src = 4'(i) + {1'b0, dec.used};
                  if (src < 4'(WIN_DEPTH)) win_in[i] = win_ff[src[2:0]];
               end
               len_in = 3'(len_ff - dec.used);
               for (int i = 0; i < MAX_RES; i++) begin
                  off = 3'(3'(i) - res_cnt_ff);
                  if ((3'(i) >= res_cnt_ff) && (off < {1'b0, dec.cnt})) begin
                     res_in[i] = dec.bytes[off[1:0]];
                  end
               end
               res_cnt_in = 3'(res_cnt_ff + {1'b0, dec.cnt});
            end
         end
         OP_EMIT: begin
            if (rsp_acc) out_idx_in = 3'(out_idx_ff + 3'd1);
            if (cond) begin
               res_cnt_in = '0;
               out_idx_in = '0;
            end
         end
         default: begin
            out_idx_in = out_idx_ff;
         end
      endcase
      pc_in = cond ? uw.on_true : uw.on_false;
   end

endmodule
